[src/u2cp_pkg.sv]
// Shared constants and the command and status words of the UTF-8 decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package u2cp_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W = 21;
  localparam int TDATA_OUT_W = 24;
  localparam int TUSER_OUT_W = 2;
  localparam int BUF_DEPTH = 4;
  localparam int CNT_W = 3;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CP4 = 21'h010000;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic out_busy;
  } status_t;

endpackage

[src/u2cp_ctrl.sv]
// Controller state machine of the UTF-8 decoder.
// Issues load, step and finish commands to the datapath; uses u2cp_pkg.
module u2cp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  u2cp_pkg::status_t status,
  output u2cp_pkg::cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd.load = in_valid && (state == IDLE);
    cmd.step = (state == RUN) && !status.out_busy;
    cmd.finish = cmd.step && status.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.load) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (cmd.finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[src/u2cp_dpath.sv]
// Datapath of the UTF-8 decoder: byte buffer, sequence decode and output register.
// Driven by the commands of u2cp_ctrl; uses u2cp_pkg.
module u2cp_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  u2cp_pkg::cmd_t                     cmd,
  output u2cp_pkg::status_t                  status,
  input  logic [u2cp_pkg::BYTE_W-1:0]        in_byte,
  input  logic                               in_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [u2cp_pkg::CP_W-1:0]          out_cp,
  output logic                               out_repl,
  output logic                               out_run_last,
  output logic                               out_text_last
);

  logic [u2cp_pkg::BYTE_W-1:0] buf_q [u2cp_pkg::BUF_DEPTH];
  logic [u2cp_pkg::CNT_W-1:0]  cnt;
  logic [u2cp_pkg::CNT_W-1:0]  pos;
  logic                        end_flag;

  logic [u2cp_pkg::BYTE_W-1:0] b, c1, c2, c3, nb;
  logic [u2cp_pkg::CNT_W-1:0]  avail, len, adv, pos_next, navail, nlen, keep;
  logic [1:0]                  shift;
  logic                        emit, stop, last, cont_ok, incomplete;
  logic [u2cp_pkg::CP_W-1:0]   cp, cp_asm, minv;
  logic                        out_repl_next;

  function automatic logic [u2cp_pkg::CNT_W-1:0] lead_len(
    input logic [u2cp_pkg::BYTE_W-1:0] v
  );
    logic [u2cp_pkg::CNT_W-1:0] r;
    if ((v & 8'hE0) == 8'hC0) begin
      r = 3'd2;
    end else if ((v & 8'hF0) == 8'hE0) begin
      r = 3'd3;
    end else if ((v & 8'hF8) == 8'hF0) begin
      r = 3'd4;
    end else begin
      r = 3'd1;
    end
    return r;
  endfunction

  function automatic logic is_cont(input logic [u2cp_pkg::BYTE_W-1:0] v);
    return (v & 8'hC0) == 8'h80;
  endfunction

  always_comb begin
    b = buf_q[pos[1:0]];
    c1 = buf_q[2'(pos + 3'd1)];
    c2 = buf_q[2'(pos + 3'd2)];
    c3 = buf_q[2'(pos + 3'd3)];
    avail = cnt - pos;
    len = lead_len(b);
    incomplete = (b[7] == 1'b1) && (len > 3'd1) && (avail < len);
    cont_ok = ((len < 3'd2) || is_cont(c1)) && ((len < 3'd3) || is_cont(c2))
              && ((len < 3'd4) || is_cont(c3));
    case (len)
      3'd2: begin
        cp_asm = {10'd0, b[4:0], c1[5:0]};
        minv = u2cp_pkg::MIN_CP2;
      end
      3'd3: begin
        cp_asm = {5'd0, b[3:0], c1[5:0], c2[5:0]};
        minv = u2cp_pkg::MIN_CP3;
      end
      3'd4: begin
        cp_asm = {b[2:0], c1[5:0], c2[5:0], c3[5:0]};
        minv = u2cp_pkg::MIN_CP4;
      end
      default: begin
        cp_asm = {13'd0, b};
        minv = '0;
      end
    endcase

    emit = 1'b1;
    stop = 1'b0;
    adv = 3'd1;
    cp = u2cp_pkg::REPL_CP;
    out_repl_next = 1'b1;
    if (b[7] == 1'b0) begin
      cp = {13'd0, b};
      out_repl_next = 1'b0;
    end else if (len == 3'd1) begin
      adv = 3'd1;
    end else if (incomplete) begin
      if (end_flag) begin
        adv = avail;
      end else begin
        emit = 1'b0;
        stop = 1'b1;
        adv = 3'd0;
      end
    end else if (cont_ok && (cp_asm >= minv) && (cp_asm <= u2cp_pkg::MAX_CP)
                 && !((cp_asm >= u2cp_pkg::SURR_LO) && (cp_asm <= u2cp_pkg::SURR_HI))) begin
      cp = cp_asm;
      out_repl_next = 1'b0;
      adv = len;
    end
    pos_next = pos + adv;

    nb = buf_q[pos_next[1:0]];
    nlen = lead_len(nb);
    navail = cnt - pos_next;
    last = stop || (pos_next >= cnt)
           || (!end_flag && (nb[7] == 1'b1) && (nlen > 3'd1) && (navail < nlen));

    keep = (end_flag || (pos_next >= cnt)) ? 3'd0 : navail;
    shift = pos_next[1:0];

    status.emit = emit;
    status.last = last;
    status.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
      end_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= cnt + 3'd1;
        pos <= '0;
        end_flag <= in_end;
      end else if (cmd.finish) begin
        cnt <= keep;
        pos <= '0;
      end else if (cmd.step) begin
        pos <= pos_next;
      end
      if (cmd.step && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_q[cnt[1:0]] <= in_byte;
    end else if (cmd.finish) begin
      for (int i = 0; i < u2cp_pkg::BUF_DEPTH; i++) begin
        buf_q[2'(i)] <= buf_q[2'(i + int'(shift))];
      end
    end
    if (cmd.step && emit) begin
      out_cp <= cp;
      out_repl <= out_repl_next;
      out_run_last <= last;
      out_text_last <= last && end_flag;
    end
  end

  a_text_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_text_last |-> out_run_last)
    else $error("text_last without run_last");

  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_repl |-> out_cp == u2cp_pkg::REPL_CP)
    else $error("replacement carries wrong code point");

  a_scalar_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_repl |-> (out_cp <= u2cp_pkg::MAX_CP)
      && !((out_cp >= u2cp_pkg::SURR_LO) && (out_cp <= u2cp_pkg::SURR_HI)))
    else $error("decoded value is not a scalar value");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> cnt < 3'd4)
    else $error("held count too large after a finished word");

endmodule

[src/utf8_to_codepoint_decoder.sv]
// An accepted byte is written to the byte buffer, then decoded in the RUN state into the output register.
// The block takes no new byte until it has given every code point that byte causes
// (up to four), one per cycle while the output is not stalled; the single decode unit sets this.
// A byte that only extends a pending sequence gives no code point.
// Reset (synchronous, rst high) empties the held bytes and the output register.
// Top level: joins u2cp_ctrl and u2cp_dpath; uses u2cp_pkg.
module utf8_to_codepoint_decoder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [u2cp_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] data_byte
  input  logic                                 s_tlast,   // end_of_text
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [u2cp_pkg::TDATA_OUT_W-1:0]     m_tdata,   // [20:0] code_point, [23:21] zero
  output logic [u2cp_pkg::TUSER_OUT_W-1:0]     m_tuser,   // [0] was_replaced, [1] run_last
  output logic                                 m_tlast    // text_last
);

  u2cp_pkg::cmd_t            cmd;
  u2cp_pkg::status_t         status;
  logic [u2cp_pkg::CP_W-1:0] cp;
  logic                      repl, run_last;

  u2cp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  u2cp_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_byte       (s_tdata),
    .in_end        (s_tlast),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_cp        (cp),
    .out_repl      (repl),
    .out_run_last  (run_last),
    .out_text_last (m_tlast)
  );

  assign m_tdata = {{(u2cp_pkg::TDATA_OUT_W - u2cp_pkg::CP_W){1'b0}}, cp};
  assign m_tuser = {run_last, repl};

endmodule

[dv/tb_utf8_to_codepoint_decoder.sv]
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_codepoint_decoder: a short table of texts, then random
// texts, decoded by a behavioural UTF-8 decoder in the bench. Needs u2cp_pkg and the RTL.
module tb_utf8_to_codepoint_decoder;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [20:0] MIN_TWO     = 21'h000080;
  localparam logic [20:0] MIN_THREE   = 21'h000800;
  localparam logic [20:0] MIN_FOUR    = 21'h010000;
  localparam int DIRECTED_LEN = 26;
  localparam int RANDOM_BYTES = 230;
  localparam int CALM_TAIL = 50;

  typedef struct packed {
    logic [20:0] cp;
    logic        repl;
    logic        run_last;
    logic        text_last;
  } cp_word_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eot;
    logic        typed;
    logic [20:0] cp;
    logic        repl;
  } row_t;

  // Fields: data byte, end of text, expected word typed in, its code point, replaced.
  localparam row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    {8'h00, 1'b1, 1'b1, 21'h000000, 1'b0},
    {8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0},
    {8'h80, 1'b1, 1'b1, REPLACEMENT, 1'b1},
    {8'hFF, 1'b1, 1'b1, REPLACEMENT, 1'b1},
    {8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hEF, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'hBD, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h8F, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'hBF, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'hBF, 1'b1, 1'b1, MAX_SCALAR, 1'b0},
    {8'hF4, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h80, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hC3, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h41, 1'b1, 1'b0, 21'h0, 1'b0},
    {8'hE2, 1'b0, 1'b0, 21'h0, 1'b0},
    {8'h82, 1'b1, 1'b1, REPLACEMENT, 1'b1}
  };

  localparam logic [20:0] EDGE_SCALARS [9] = '{
    21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
    21'h00E000, 21'h00FFFF, 21'h010000, 21'h10FFFF
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [u2cp_pkg::BYTE_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [u2cp_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic [u2cp_pkg::TUSER_OUT_W-1:0] m_tuser;
  logic m_tlast;

  logic calm = 1'b0;
  row_t row_now = '0;
  int errors = 0;

  logic [7:0] pend_bytes [3];
  int pend_count = 0;
  cp_word_t new_cps [$];
  cp_word_t expected_cps [$];
  cp_word_t want;
  logic [7:0] unit_bytes [$];
  row_t stim_rows [$];

  utf8_to_codepoint_decoder uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void emit_cp(logic [20:0] cp, logic repl);
    new_cps.insert(new_cps.size(), cp_word_t'({cp, repl, 1'b0, 1'b0}));
  endfunction

  function automatic void add_unit_byte(logic [7:0] v);
    unit_bytes.insert(unit_bytes.size(), v);
  endfunction

  // Decodes one byte against the held bytes and leaves its code points in new_cps.
  function automatic void decode_byte(logic [7:0] data, logic eot);
    logic [7:0] seq [4];
    logic [7:0] b;
    logic [7:0] c;
    logic [20:0] cp;
    logic [20:0] minv;
    logic ok;
    int n, pos, len, k;
    new_cps.delete();
    n = pend_count;
    for (k = 0; k < n; k++) seq[k] = pend_bytes[k];
    seq[n] = data;
    n++;
    pos = 0;
    while (pos < n) begin
      b = seq[pos];
      if (!b[7]) begin
        emit_cp({13'd0, b}, 1'b0);
        pos++;
        continue;
      end
      if (b[7:5] == 3'b110) begin
        cp = {16'd0, b[4:0]}; len = 2; minv = MIN_TWO;
      end else if (b[7:4] == 4'b1110) begin
        cp = {17'd0, b[3:0]}; len = 3; minv = MIN_THREE;
      end else if (b[7:3] == 5'b11110) begin
        cp = {18'd0, b[2:0]}; len = 4; minv = MIN_FOUR;
      end else begin
        emit_cp(REPLACEMENT, 1'b1);
        pos++;
        continue;
      end
      if (n - pos < len) begin
        if (eot) begin
          emit_cp(REPLACEMENT, 1'b1);
          pos = n;
        end
        break;
      end
      ok = 1'b1;
      for (k = 1; k < len; k++) begin
        c = seq[pos + k];
        if (c[7:6] != 2'b10) begin
          ok = 1'b0;
          break;
        end
        cp = {cp[14:0], c[5:0]};
      end
      if (!ok || cp < minv || cp > MAX_SCALAR || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
        emit_cp(REPLACEMENT, 1'b1);
        pos++;
        continue;
      end
      emit_cp(cp, 1'b0);
      pos += len;
    end
    if (eot || pos >= n) begin
      pend_count = 0;
    end else begin
      pend_count = n - pos;
      for (k = 0; k < pend_count; k++) pend_bytes[k] = seq[pos + k];
    end
    if (new_cps.size() > 0) begin
      new_cps[new_cps.size() - 1].run_last = 1'b1;
      new_cps[new_cps.size() - 1].text_last = eot;
    end
  endfunction

  function automatic void encode_cp(logic [20:0] cp);
    unit_bytes.delete();
    if (cp < MIN_TWO) begin
      add_unit_byte(cp[7:0]);
    end else if (cp < MIN_THREE) begin
      add_unit_byte({3'b110, cp[10:6]});
      add_unit_byte({2'b10, cp[5:0]});
    end else if (cp < MIN_FOUR) begin
      add_unit_byte({4'b1110, cp[15:12]});
      add_unit_byte({2'b10, cp[11:6]});
      add_unit_byte({2'b10, cp[5:0]});
    end else begin
      add_unit_byte({5'b11110, cp[20:18]});
      add_unit_byte({2'b10, cp[17:12]});
      add_unit_byte({2'b10, cp[11:6]});
      add_unit_byte({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [20:0] random_scalar();
    logic [20:0] cp;
    case ($urandom_range(0, 4))
      0: cp = 21'($urandom_range(0, 'h7F));
      1: cp = 21'($urandom_range('h80, 'h7FF));
      2: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SURR_FIRST && cp <= SURR_LAST) cp = cp + 21'h800;
      end
      3: cp = 21'($urandom_range('h10000, 'h10FFFF));
      default: cp = EDGE_SCALARS[4'($urandom_range(0, 8))];
    endcase
    return cp;
  endfunction

  function automatic logic [7:0] tail_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // Mostly well-formed characters; the rest are the ways a sequence goes wrong.
  function automatic void random_unit();
    logic [7:0] r;
    int idx;
    case ($urandom_range(0, 15))
      9: begin
        unit_bytes.delete();
        add_unit_byte(8'($urandom_range(0, 255)));
      end
      10: begin
        encode_cp(random_scalar());
        if (unit_bytes.size() > 1)
          repeat ($urandom_range(1, unit_bytes.size() - 1)) void'(unit_bytes.pop_back());
      end
      11: begin
        encode_cp(random_scalar());
        if (unit_bytes.size() > 1) begin
          idx = $urandom_range(1, unit_bytes.size() - 1);
          r = 8'($urandom_range(0, 255));
          if (r[7:6] == 2'b10) r[6] = 1'b1;
          unit_bytes[idx] = r;
        end
      end
      12: begin
        unit_bytes.delete();
        case ($urandom_range(0, 2))
          0: add_unit_byte({7'b1100000, 1'($urandom_range(0, 1))});
          1: begin
            add_unit_byte(8'hE0);
            add_unit_byte({3'b100, 5'($urandom_range(0, 31))});
          end
          default: begin
            add_unit_byte(8'hF0);
            add_unit_byte({4'b1000, 4'($urandom_range(0, 15))});
            add_unit_byte(tail_byte());
          end
        endcase
        add_unit_byte(tail_byte());
      end
      13: begin
        unit_bytes.delete();
        add_unit_byte(8'hED);
        add_unit_byte({3'b101, 5'($urandom_range(0, 31))});
        add_unit_byte(tail_byte());
      end
      14: begin
        unit_bytes.delete();
        if ($urandom_range(0, 1)) begin
          add_unit_byte(8'hF4);
          add_unit_byte(8'($urandom_range('h90, 'hBF)));
        end else begin
          add_unit_byte(8'($urandom_range('hF5, 'hF7)));
          add_unit_byte(tail_byte());
        end
        add_unit_byte(tail_byte());
        add_unit_byte(tail_byte());
      end
      15: begin
        unit_bytes.delete();
        if ($urandom_range(0, 1)) add_unit_byte(8'($urandom_range('h80, 'hBF)));
        else add_unit_byte(8'($urandom_range('hF8, 'hFF)));
      end
      default: encode_cp(random_scalar());
    endcase
  endfunction

  initial begin
    int i;
    int first_random;
    row_t row;
    for (i = 0; i < DIRECTED_LEN; i++) stim_rows.insert(stim_rows.size(), DIRECTED_ROWS[i]);
    first_random = stim_rows.size();
    while (stim_rows.size() - first_random < RANDOM_BYTES) begin
      repeat ($urandom_range(1, 10)) begin
        random_unit();
        foreach (unit_bytes[k])
          stim_rows.insert(stim_rows.size(), row_t'({unit_bytes[k], 1'b0, 1'b0, 21'h0, 1'b0}));
      end
      stim_rows[stim_rows.size() - 1].eot = 1'b1;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < stim_rows.size(); i++) begin
      row = stim_rows[i];
      calm <= (i >= stim_rows.size() - CALM_TAIL);
      if (i == DIRECTED_LEN || i == first_random + RANDOM_BYTES / 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_cps.size() != 0) @(posedge clk);
      end else if (i < stim_rows.size() - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= row.data;
      s_tlast <= row.eot;
      row_now <= row;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (errors == 0 && expected_cps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    forever begin
      if (calm || $urandom_range(0, 4) != 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      decode_byte(s_tdata, s_tlast);
      if (row_now.typed)
        expected_cps.insert(expected_cps.size(),
                            cp_word_t'({row_now.cp, row_now.repl, 1'b1, row_now.eot}));
      else foreach (new_cps[k]) expected_cps.insert(expected_cps.size(), new_cps[k]);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_cps.size() == 0) begin
        $error("unexpected word: code_point 0x%h", m_tdata[20:0]);
        errors++;
      end else begin
        want = expected_cps.pop_front();
        if (m_tdata[20:0] !== want.cp) begin
          $error("code_point: expected 0x%h, got 0x%h", want.cp, m_tdata[20:0]);
          errors++;
        end
        if (m_tdata[u2cp_pkg::TDATA_OUT_W-1:21] !== '0) begin
          $error("tdata padding: expected 0, got %b", m_tdata[u2cp_pkg::TDATA_OUT_W-1:21]);
          errors++;
        end
        if (m_tuser[0] !== want.repl) begin
          $error("was_replaced: expected %b, got %b", want.repl, m_tuser[0]);
          errors++;
        end
        if (m_tuser[1] !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, m_tuser[1]);
          errors++;
        end
        if (m_tlast !== want.text_last) begin
          $error("text_last: expected %b, got %b", want.text_last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
